// ----- hdl/sledec_pkg.sv -----
// Package for the string literal escape decoder: phase, status and mode codes,
// character constants, the shader prefix text and the hex digit decoder.
// No dependencies.
package sledec_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PREFIX = 3'd1,
    PH_BODY   = 3'd2,
    PH_ESC    = 3'd3,
    PH_HEX1   = 3'd4,
    PH_HEX2   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_CLOSE = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_RAW    = 2'd1,
    MODE_SHADER = 2'd2
  } mode_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    mode_t      mode;
    logic       last;
  } result_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [2:0] PREFIX_LAST = 3'd7;

  // Text @Shader" indexed by prefix position
  function automatic logic [7:0] shader_tag(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h40;
      3'd1:    c = 8'h53;
      3'd2:    c = 8'h68;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h64;
      3'd5:    c = 8'h65;
      3'd6:    c = 8'h72;
      default: c = 8'h22;
    endcase
    return c;
  endfunction

  // Bit 4 set when the character is a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage

// ----- hdl/string_literal_escape_decoder.sv -----
// String literal escape decoder, top level.
// Depends on sledec_pkg.
//
// Usage: requests carry one character of a source line (ch) with start_req
// marking the opening character of a literal and line_end marking the end of
// the line (ch ignored). An opening character other than @ (such as a quote) opens a
// normal literal, @" a raw one and @Shader" a shader one. Results carry status (data, close, error), the
// decoded byte, the literal mode and last, set on the final result of a
// request. A request gives zero, one or two results.
// Order: a request is held in the input register, then decoded into the
// result queue, whose head entry is offered on the output.
// Throughput: one request per cycle while results drain at one per cycle; a
// request giving two results fills two queue entries. The rate is set by the
// single output port of the four-entry result queue.
// Reset: synchronous, clears the phase, mode and queue; the block is idle.
// Stall: when out_ready is low the queue fills; the input register holds
// while fewer than two queue entries are free, and in_ready then drops.
module string_literal_escape_decoder
  import sledec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       start_req,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [7:0] data,
  output logic [1:0] mode,
  output logic       last
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // input register
  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_start;
  logic       s1_lend;
  logic       s1_fire;

  // decoder state
  phase_t     phase, phase_next;
  mode_t      lit_mode, lit_mode_next;
  logic [2:0] prefix_index, prefix_index_next;
  logic [3:0] hex_high, hex_high_next;

  // result queue
  result_t          queue [QDepth];
  logic [QAw-1:0]   wr_ptr;
  logic [QAw-1:0]   rd_ptr;
  logic [QAw:0]     count;
  logic             pop;

  logic [1:0]  n_res;
  status_t     r0_status;
  logic [7:0]  r0_data;
  logic [7:0]  r1_data;
  logic [4:0]  hv;
  result_t     res0, res1;

  assign s1_fire  = s1_valid && (count <= (QAw+1)'(QDepth - 2));
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ch    <= ch;
      s1_start <= start_req;
      s1_lend  <= line_end;
    end
  end

  always_comb begin
    phase_next        = phase;
    lit_mode_next     = lit_mode;
    prefix_index_next = prefix_index;
    hex_high_next     = hex_high;
    n_res             = 2'd0;
    r0_status         = ST_DATA;
    r0_data           = 8'h00;
    r1_data           = 8'h00;
    hv                = hex_value(s1_ch);
    if (s1_lend) begin
      if (phase != PH_IDLE) begin
        n_res     = 2'd1;
        r0_status = ST_ERROR;
      end
      phase_next = PH_IDLE;
    end else if (s1_start) begin
      // drop any literal in progress
      lit_mode_next     = MODE_NORMAL;
      hex_high_next     = 4'd0;
      if (s1_ch == CH_AT) begin
        phase_next        = PH_PREFIX;
        prefix_index_next = 3'd1;
      end else begin
        phase_next        = PH_BODY;
        prefix_index_next = 3'd0;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_PREFIX: begin
          if (prefix_index == 3'd1 && s1_ch == CH_QUOTE) begin
            lit_mode_next = MODE_RAW;
            phase_next    = PH_BODY;
          end else if (prefix_index != 3'd0 && s1_ch == shader_tag(prefix_index)) begin
            if (prefix_index == PREFIX_LAST) begin
              lit_mode_next = MODE_SHADER;
              phase_next    = PH_BODY;
            end else begin
              prefix_index_next = prefix_index + 3'd1;
            end
          end else begin
            n_res      = 2'd1;
            r0_status  = ST_ERROR;
            phase_next = PH_IDLE;
          end
        end
        PH_BODY: begin
          if (s1_ch == CH_QUOTE) begin
            n_res      = 2'd1;
            r0_status  = ST_CLOSE;
            phase_next = PH_IDLE;
          end else if (lit_mode != MODE_RAW && s1_ch == CH_BSLASH) begin
            phase_next = PH_ESC;
          end else begin
            n_res   = 2'd1;
            r0_data = s1_ch;
          end
        end
        PH_ESC: begin
          phase_next = PH_BODY;
          if (s1_ch == CH_QUOTE || s1_ch == CH_BSLASH) begin
            n_res   = 2'd1;
            r0_data = s1_ch;
          end else if (s1_ch == CH_N) begin
            n_res   = 2'd1;
            r0_data = CH_LF;
          end else if (s1_ch == CH_T) begin
            n_res   = 2'd1;
            r0_data = CH_TAB;
          end else if (s1_ch == CH_X) begin
            phase_next = PH_HEX1;
          end else begin
            // unknown escape: pass the backslash and the character on
            n_res   = 2'd2;
            r0_data = CH_BSLASH;
            r1_data = s1_ch;
          end
        end
        PH_HEX1: begin
          if (!hv[4]) begin
            n_res      = 2'd1;
            r0_status  = ST_ERROR;
            phase_next = PH_IDLE;
          end else begin
            hex_high_next = hv[3:0];
            phase_next    = PH_HEX2;
          end
        end
        PH_HEX2: begin
          if (!hv[4]) begin
            n_res      = 2'd1;
            r0_status  = ST_ERROR;
            phase_next = PH_IDLE;
          end else begin
            n_res      = 2'd1;
            r0_data    = {hex_high, hv[3:0]};
            phase_next = PH_BODY;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      lit_mode     <= MODE_NORMAL;
      prefix_index <= 3'd0;
      hex_high     <= 4'd0;
    end else if (s1_fire) begin
      phase        <= phase_next;
      lit_mode     <= lit_mode_next;
      prefix_index <= prefix_index_next;
      hex_high     <= hex_high_next;
    end
  end

  // mode is that of the literal before this request, no result follows a change
  assign res0 = '{status: r0_status, data: r0_data, mode: lit_mode,
                  last: (n_res == 2'd1)};
  assign res1 = '{status: ST_DATA, data: r1_data, mode: lit_mode, last: 1'b1};

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (s1_fire && n_res != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (s1_fire && n_res == 2'd2) begin
      queue[wr_ptr + QAw'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s1_fire) begin
        wr_ptr <= wr_ptr + QAw'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAw'(1);
      end
      count <= count + (QAw+1)'(s1_fire ? n_res : 2'd0) - (QAw+1)'(pop);
    end
  end

  assign status = queue[rd_ptr].status;
  assign data   = queue[rd_ptr].data;
  assign mode   = queue[rd_ptr].mode;
  assign last   = queue[rd_ptr].last;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAw+1)'(QDepth))
    else $error("result queue overflow");

  a_room_on_fire: assert property (@(posedge clk) disable iff (rst)
    s1_fire |-> count <= (QAw+1)'(QDepth - 2))
    else $error("request decoded without room for two results");

  a_lend_idles: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_lend) |=> phase == PH_IDLE)
    else $error("line end did not return to idle");

  a_escape_not_raw: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ESC || phase == PH_HEX1 || phase == PH_HEX2) |-> lit_mode != MODE_RAW)
    else $error("escape decoding in raw literal");

  a_prefix_index: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PREFIX |-> prefix_index != 3'd0)
    else $error("prefix phase with zero position");
`endif

endmodule

// ----- tb/sv/sledec_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the string literal escape decoder: watches both channels,
// predicts the decoded results of every request and compares them in order.
// Depends on sledec_pkg.
module sledec_result_checker
  import sledec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] ch,
  input  logic       start_req,
  input  logic       line_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] status,
  input  logic [7:0] data,
  input  logic [1:0] mode,
  input  logic       last,
  output int         fail_count,
  output int         outstanding
);

  localparam logic [63:0] SHADER_TEXT =
    {CH_AT, 8'h53, 8'h68, 8'h61, 8'h64, 8'h65, 8'h72, CH_QUOTE};
  localparam int MAX_REPORTS = 40;

  phase_t     lit_phase;
  mode_t      lit_mode;
  logic [2:0] tag_pos;
  logic [3:0] hi_nibble;
  result_t    decoded_q[$];

  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    return SHADER_TEXT[63 - 8 * pos -: 8];
  endfunction

  // -1 for anything that is not a hex digit
  function automatic int digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    return -1;
  endfunction

  function automatic result_t make_result(input status_t s, input logic [7:0] d);
    result_t r;
    r.status = s;
    r.data   = d;
    r.mode   = lit_mode;
    r.last   = 1'b0;
    return r;
  endfunction

  task automatic decode_char(input logic [7:0] c, input logic opening, input logic lend);
    result_t res[2];
    int      n;
    int      v;
    n = 0;
    if (lend) begin
      if (lit_phase != PH_IDLE) begin
        res[n] = make_result(ST_ERROR, 8'h00);
        n++;
      end
      lit_phase = PH_IDLE;
    end else if (opening) begin
      // Drop any literal in progress
      lit_mode  = MODE_NORMAL;
      tag_pos   = 3'd0;
      hi_nibble = 4'd0;
      if (c == CH_AT) begin
        lit_phase = PH_PREFIX;
        tag_pos   = 3'd1;
      end else begin
        lit_phase = PH_BODY;
      end
    end else begin
      case (lit_phase)
        PH_PREFIX: begin
          if (tag_pos == 3'd1 && c == CH_QUOTE) begin
            lit_mode  = MODE_RAW;
            lit_phase = PH_BODY;
          end else if (tag_pos != 3'd0 && c == tag_char(tag_pos)) begin
            if (tag_pos == PREFIX_LAST) begin
              lit_mode  = MODE_SHADER;
              lit_phase = PH_BODY;
            end else begin
              tag_pos = tag_pos + 3'd1;
            end
          end else begin
            res[n] = make_result(ST_ERROR, 8'h00);
            n++;
            lit_phase = PH_IDLE;
          end
        end
        PH_BODY: begin
          if (c == CH_QUOTE) begin
            res[n] = make_result(ST_CLOSE, 8'h00);
            n++;
            lit_phase = PH_IDLE;
          end else if (lit_mode != MODE_RAW && c == CH_BSLASH) begin
            lit_phase = PH_ESC;
          end else begin
            res[n] = make_result(ST_DATA, c);
            n++;
          end
        end
        PH_ESC: begin
          lit_phase = PH_BODY;
          if (c == CH_QUOTE || c == CH_BSLASH) begin
            res[n] = make_result(ST_DATA, c);
            n++;
          end else if (c == CH_N) begin
            res[n] = make_result(ST_DATA, CH_LF);
            n++;
          end else if (c == CH_T) begin
            res[n] = make_result(ST_DATA, CH_TAB);
            n++;
          end else if (c == CH_X) begin
            lit_phase = PH_HEX1;
          end else begin
            // Unknown escape: pass the backslash and the character through
            res[0] = make_result(ST_DATA, CH_BSLASH);
            res[1] = make_result(ST_DATA, c);
            n = 2;
          end
        end
        PH_HEX1: begin
          v = digit_value(c);
          if (v < 0) begin
            res[n] = make_result(ST_ERROR, 8'h00);
            n++;
            lit_phase = PH_IDLE;
          end else begin
            hi_nibble = v[3:0];
            lit_phase = PH_HEX2;
          end
        end
        PH_HEX2: begin
          v = digit_value(c);
          if (v < 0) begin
            res[n] = make_result(ST_ERROR, 8'h00);
            n++;
            lit_phase = PH_IDLE;
          end else begin
            res[n] = make_result(ST_DATA, {hi_nibble, v[3:0]});
            n++;
            lit_phase = PH_BODY;
          end
        end
        default: lit_phase = PH_IDLE;
      endcase
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) res[i].last = 1'b1;
      decoded_q.push_back(res[i]);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      lit_phase = PH_IDLE;
      lit_mode  = MODE_NORMAL;
      tag_pos   = 3'd0;
      hi_nibble = 4'd0;
      decoded_q.delete();
    end else begin
      if (in_valid && in_ready) decode_char(ch, start_req, line_end);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result: status=%0d data=0x%02h mode=%0d last=%0d",
                     $time, status, data, mode, last);
        end else begin
          want = decoded_q.pop_front();
          if (status !== want.status || data !== want.data ||
              mode !== want.mode || last !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"%0t: result mismatch: expected status=%0d data=0x%02h mode=%0d",
                        " last=%0d, actual status=%0d data=0x%02h mode=%0d last=%0d"},
                       $time, want.status, want.data, want.mode, want.last,
                       status, data, mode, last);
          end
        end
      end
    end
    outstanding = decoded_q.size();
  end

endmodule

// ----- tb/sv/string_literal_escape_decoder_tb.sv -----
`timescale 1ns / 1ps
// Top of the string literal escape decoder testbench: builds directed and
// random literals, drives requests with random idling and stalls the results.
// Depends on sledec_pkg, sledec_result_checker and the decoder itself.
module string_literal_escape_decoder_tb;
  import sledec_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       start;
    logic       lend;
  } char_req_t;

  localparam int RANDOM_ITEMS = 2000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] ch;
  logic       start_req;
  logic       line_end;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] status;
  logic [7:0] data;
  logic [1:0] mode;
  logic       last;
  int         fail_count;
  int         outstanding;

  char_req_t  char_q[$];
  int         calm_left;

  string_literal_escape_decoder dut (.*);
  sledec_result_checker u_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void add_req(input logic [7:0] c, input logic s, input logic le);
    char_req_t r;
    r.ch    = c;
    r.start = s;
    r.lend  = le;
    char_q.push_back(r);
  endfunction

  function automatic void add_text(input string t);
    for (int i = 0; i < t.len(); i++) add_req(t[i], 1'b0, 1'b0);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 8'd10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h00, 8'h2F));
      1:       return 8'($urandom_range(8'h3A, 8'h40));
      2:       return 8'($urandom_range(8'h47, 8'h60));
      default: return 8'($urandom_range(8'h67, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] rand_plain(input bit raw);
    logic [7:0] c;
    if (raw && $urandom_range(0, 9) == 0) return CH_BSLASH;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_QUOTE || (!raw && c == CH_BSLASH));
    return c;
  endfunction

  // One literal: opening, optional prefix, body with escapes, then a close,
  // a line end or nothing (the next opening drops it)
  function automatic void add_literal();
    int         k;
    int         pos;
    int         len;
    bit         raw;
    string      tag;
    logic [7:0] c;
    raw = 1'b0;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      add_req(CH_QUOTE, 1'b1, 1'b0);
    end else if (k < 48) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_AT);
      add_req(c, 1'b1, 1'b0);
    end else begin
      raw = (k < 72);
      tag = raw ? "@\"" : "@Shader\"";
      add_req(CH_AT, 1'b1, 1'b0);
      if ($urandom_range(0, 99) < 10) begin
        pos = $urandom_range(1, tag.len() - 1);
        for (int i = 1; i < pos; i++) add_req(tag[i], 1'b0, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          add_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else begin
          do c = 8'($urandom_range(0, 255));
          while (c == tag[pos] || (pos == 1 && (c == CH_QUOTE || c == 8'h53)));
          add_req(c, 1'b0, 1'b0);
        end
        return;
      end
      for (int i = 1; i < tag.len(); i++) add_req(tag[i], 1'b0, 1'b0);
    end
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      if (!raw && $urandom_range(0, 99) < 35) begin
        add_req(CH_BSLASH, 1'b0, 1'b0);
        case ($urandom_range(0, 9))
          0: add_req(CH_QUOTE, 1'b0, 1'b0);
          1: add_req(CH_BSLASH, 1'b0, 1'b0);
          2: add_req(CH_N, 1'b0, 1'b0);
          3: add_req(CH_T, 1'b0, 1'b0);
          4, 5: begin
            add_req(CH_X, 1'b0, 1'b0);
            add_req(rand_hex_char(), 1'b0, 1'b0);
            add_req(rand_hex_char(), 1'b0, 1'b0);
          end
          6: begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_QUOTE || c == CH_BSLASH || c == CH_N || c == CH_T || c == CH_X);
            add_req(c, 1'b0, 1'b0);
          end
          7: begin
            add_req(CH_X, 1'b0, 1'b0);
            add_req(rand_non_hex(), 1'b0, 1'b0);
            return;
          end
          8: begin
            add_req(CH_X, 1'b0, 1'b0);
            add_req(rand_hex_char(), 1'b0, 1'b0);
            add_req(rand_non_hex(), 1'b0, 1'b0);
            return;
          end
          default: begin
            // Cut the escape short with a line end
            pos = $urandom_range(0, 2);
            if (pos > 0) add_req(CH_X, 1'b0, 1'b0);
            if (pos > 1) add_req(rand_hex_char(), 1'b0, 1'b0);
            add_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            return;
          end
        endcase
      end else begin
        add_req(rand_plain(raw), 1'b0, 1'b0);
      end
    end
    k = $urandom_range(0, 99);
    if (k < 82)
      add_req(CH_QUOTE, 1'b0, 1'b0);
    else if (k < 92)
      add_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endfunction

  function automatic void build_directed();
    // Every escape in a normal literal, a top-bit byte, then close
    add_req(CH_QUOTE, 1'b1, 1'b0);
    add_text("\\\"\\\\\\n\\t\\x4f\\q");
    add_req(8'hFF, 1'b0, 1'b0);
    add_req(CH_QUOTE, 1'b0, 1'b0);
    // Raw literal: backslash is plain data
    add_req(CH_AT, 1'b1, 1'b0);
    add_text("\"\\\"");
    // Shader literal cut by a line end while waiting for the second hex digit
    add_req(CH_AT, 1'b1, 1'b0);
    add_text("Shader\"\\xF");
    add_req(8'h00, 1'b0, 1'b1);
    // Opening other than a quote, then a bad first hex digit
    add_req(8'h61, 1'b1, 1'b0);
    add_text("\\xg");
    // Bad prefix, then a character and a line end while idle
    add_req(CH_AT, 1'b1, 1'b0);
    add_req(8'h58, 1'b0, 1'b0);
    add_req(8'h7A, 1'b0, 1'b0);
    add_req(8'hFF, 1'b0, 1'b1);
    // Start while busy, then line end together with start inside the prefix
    add_req(CH_QUOTE, 1'b1, 1'b0);
    add_req(8'h6B, 1'b0, 1'b0);
    add_req(CH_AT, 1'b1, 1'b0);
    add_req(CH_AT, 1'b1, 1'b1);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_req(input char_req_t r);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(50, 200);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    ch        <= r.ch;
    start_req <= r.start;
    line_end  <= r.lend;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Result side back-pressure
  initial begin
    int r;
    int hold;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_ready <= 1'b1;
        hold = $urandom_range(1, 20);
      end else if (r < 60) begin
        out_ready <= 1'b1;
        hold = $urandom_range(100, 300);
      end else if (r < 92) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        hold = $urandom_range(20, 60);
      end
      repeat (hold - 1) @(negedge clk);
    end
  end

  initial begin
    int target;
    rst       = 1'b1;
    in_valid  = 1'b0;
    ch        = 8'h00;
    start_req = 1'b0;
    line_end  = 1'b0;
    calm_left = 0;
    build_directed();
    target = char_q.size() + RANDOM_ITEMS;
    while (char_q.size() < target) begin
      add_literal();
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 3)) add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      if ($urandom_range(0, 99) < 4) add_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (char_q[i]) drive_req(char_q[i]);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
